// File: rtl/rva_pkg.sv
// ----------------------------------------------------------------------------
// rva_pkg
// Shared widths, stage counts and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rva_pkg;

    localparam int DEF_DATA_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int UNIT_FRAC    = 30;
    localparam int ANG_FRAC     = 24;
    localparam int CORDIC_STEPS = 24;
    localparam longint CORDIC_GAIN = 652032874;

    // dependent steps folded into one register stage
    localparam int SPS = 2;

    localparam int MAG_W  = 30;          // scaled axis magnitude
    localparam int ROOT_W = 31;          // length and quotient bits
    localparam int WIDE_W = 62;          // sum of squares, dividend
    localparam int UW     = 32;          // unit component, Q30 signed
    localparam int CW     = 34;          // CORDIC datapath, signed
    localparam int MW     = 36;          // matrix entry, Q30 signed

    localparam int SQRT_STAGES   = (ROOT_W + SPS - 1) / SPS;
    localparam int DIV_STAGES    = (ROOT_W + SPS - 1) / SPS;
    localparam int CORDIC_STAGES = (CORDIC_STEPS + SPS - 1) / SPS;

    localparam int AXIS_LAT = 3 + SQRT_STAGES + 1 + DIV_STAGES + 1;
    localparam int MAT_LAT  = 3;
    localparam int OUT_LAT  = 2;

    function automatic int f_red_steps(input int dw, input int fb);
        int iw;
        iw = dw - fb;
        return ((iw > 8) ? (iw - 8) : 0) + 1;
    endfunction

    function automatic int f_ang_lat(input int dw, input int fb);
        return 1 + (f_red_steps(dw, fb) + SPS - 1) / SPS + 1 + CORDIC_STAGES + 1;
    endfunction

    function automatic int f_mat_frac(input int dw);
        return ((60 - dw) > UNIT_FRAC) ? UNIT_FRAC : (60 - dw);
    endfunction

    // atan(2^-i) in Q24 degrees
    function automatic logic signed [CW-1:0] f_atan(input int i);
        logic signed [CW-1:0] v;
        case (i)
            0:  v = CW'(754974720);
            1:  v = CW'(445687602);
            2:  v = CW'(235489088);
            3:  v = CW'(119537938);
            4:  v = CW'(60000934);
            5:  v = CW'(30029717);
            6:  v = CW'(15018523);
            7:  v = CW'(7509720);
            8:  v = CW'(3754917);
            9:  v = CW'(1877466);
            10: v = CW'(938734);
            11: v = CW'(469367);
            12: v = CW'(234684);
            13: v = CW'(117342);
            14: v = CW'(58671);
            15: v = CW'(29335);
            16: v = CW'(14668);
            17: v = CW'(7334);
            18: v = CW'(3667);
            19: v = CW'(1833);
            20: v = CW'(917);
            21: v = CW'(458);
            22: v = CW'(229);
            23: v = CW'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/rva_axis.sv
// ----------------------------------------------------------------------------
// rva_axis
// Axis to unit vector: prescale, sum of squares, pipelined integer square
// root and three pipelined rounded divisions, all in Q30.
// ----------------------------------------------------------------------------
module rva_axis #(
    parameter int DATA_WIDTH = rva_pkg::DEF_DATA_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [DATA_WIDTH-1:0]      i_axis [3],
    output logic signed [rva_pkg::UW-1:0]     o_unit [3]
);

    localparam int DW  = DATA_WIDTH;
    localparam int PW  = $clog2(DW);
    localparam int MB  = rva_pkg::MAG_W;
    localparam int RW  = rva_pkg::ROOT_W;
    localparam int WW  = rva_pkg::WIDE_W;
    localparam int SQS = rva_pkg::SQRT_STAGES;
    localparam int DVS = rva_pkg::DIV_STAGES;
    localparam int SPS = rva_pkg::SPS;

    // stage 1: magnitudes scaled so the largest has its top bit at 29
    logic [DW-1:0]    n_mag [3];
    logic [DW-1:0]    n_or;
    logic [PW-1:0]    n_p;
    logic [DW+28:0]   n_wide [3];
    logic [MB-1:0]    r_m1 [3];
    logic             r_sg1 [3];

    always_comb begin
        n_or = '0;
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = i_axis[i][DW-1] ? DW'(-i_axis[i]) : DW'(i_axis[i]);
            n_or     = n_or | n_mag[i];
        end
        n_p = '0;
        for (int b = 0; b < DW; b++) begin
            if (n_or[b]) begin
                n_p = PW'(b);
            end
        end
        for (int i = 0; i < 3; i++) begin
            n_wide[i] = ((DW+29)'(n_mag[i]) << 29) >> n_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m1[i]  <= n_wide[i][MB-1:0];
                r_sg1[i] <= i_axis[i][DW-1];
            end
        end
    end

    // stage 2: squares
    logic [2*MB-1:0] r_sq [3];
    logic [MB-1:0]   r_m2 [3];
    logic            r_sg2 [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i]  <= r_m1[i] * r_m1[i];
                r_m2[i]  <= r_m1[i];
                r_sg2[i] <= r_sg1[i];
            end
        end
    end

    // stage 3 feeds the root chain: remainder, partial root
    logic [WW-1:0] r_rem  [0:SQS];
    logic [RW-1:0] r_root [0:SQS];
    logic [MB-1:0] r_ms   [0:SQS][3];
    logic          r_ss   [0:SQS][3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= WW'(r_sq[0]) + WW'(r_sq[1]) + WW'(r_sq[2]);
            r_root[0] <= '0;
            for (int i = 0; i < 3; i++) begin
                r_ms[0][i] <= r_m2[i];
                r_ss[0][i] <= r_sg2[i];
            end
        end
    end

    for (genvar g = 0; g < SQS; g++) begin : g_sqrt
        logic [WW-1:0] n_rem;
        logic [RW-1:0] n_root;

        always_comb begin
            int            k;
            logic [WW-1:0] d;
            n_rem  = r_rem[g];
            n_root = r_root[g];
            for (int j = 0; j < SPS; j++) begin
                k = RW - 1 - g * SPS - j;
                if (k >= 0) begin
                    d = (WW'(n_root) << (k + 1)) | (WW'(1) << (2 * k));
                    if (n_rem >= d) begin
                        n_rem  = n_rem - d;
                        n_root = n_root | (RW'(1) << k);
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= n_rem;
                r_root[g+1] <= n_root;
                r_ms[g+1]   <= r_ms[g];
                r_ss[g+1]   <= r_ss[g];
            end
        end
    end

    // dividend with half the divisor added for round half up
    logic [WW-1:0] r_num [0:DVS][3];
    logic [RW-1:0] r_q   [0:DVS][3];
    logic [RW-1:0] r_len [0:DVS];
    logic          r_sd  [0:DVS][3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len[0] <= r_root[SQS];
            for (int i = 0; i < 3; i++) begin
                r_num[0][i] <= (WW'(r_ms[SQS][i]) << rva_pkg::UNIT_FRAC)
                             + WW'(r_root[SQS] >> 1);
                r_q[0][i]   <= '0;
                r_sd[0][i]  <= r_ss[SQS][i];
            end
        end
    end

    for (genvar g = 0; g < DVS; g++) begin : g_div
        logic [WW-1:0] n_num [3];
        logic [RW-1:0] n_q   [3];

        always_comb begin
            int            k;
            logic [WW-1:0] d;
            for (int i = 0; i < 3; i++) begin
                n_num[i] = r_num[g][i];
                n_q[i]   = r_q[g][i];
                for (int j = 0; j < SPS; j++) begin
                    k = RW - 1 - g * SPS - j;
                    if (k >= 0) begin
                        d = WW'(r_len[g]) << k;
                        if (n_num[i] >= d) begin
                            n_num[i] = n_num[i] - d;
                            n_q[i]   = n_q[i] | (RW'(1) << k);
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[g+1] <= n_num;
                r_q[g+1]   <= n_q;
                r_len[g+1] <= r_len[g];
                r_sd[g+1]  <= r_sd[g];
            end
        end
    end

    // restore the component signs
    logic signed [rva_pkg::UW-1:0] r_unit [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_unit[i] <= r_sd[DVS][i] ? -$signed(rva_pkg::UW'(r_q[DVS][i]))
                                          :  $signed(rva_pkg::UW'(r_q[DVS][i]));
            end
        end
    end

    assign o_unit = r_unit;

endmodule

// File: rtl/rva_ang.sv
// ----------------------------------------------------------------------------
// rva_ang
// Angle reduction modulo 360 degrees, quadrant fold and a pipelined
// degree-based CORDIC giving cosine and sine in Q30.
// ----------------------------------------------------------------------------
module rva_ang #(
    parameter int DATA_WIDTH = rva_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = rva_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [DATA_WIDTH-1:0]         i_angle,
    output logic signed [rva_pkg::CW-1:0] o_cos,
    output logic signed [rva_pkg::CW-1:0] o_sin
);

    localparam int DW   = DATA_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int CW   = rva_pkg::CW;
    localparam int AF   = rva_pkg::ANG_FRAC;
    localparam int IW   = DW - FB;
    localparam int VW   = IW + 2;
    localparam int NRED = rva_pkg::f_red_steps(DW, FB);
    localparam int NRS  = (NRED + rva_pkg::SPS - 1) / rva_pkg::SPS;
    localparam int NCS  = rva_pkg::CORDIC_STAGES;
    localparam int SPS  = rva_pkg::SPS;
    // multiple of 360 that lifts any integer part to a nonnegative value
    localparam longint OFFS = 360 * (((longint'(1) << (IW - 1)) + 359) / 360);
    localparam logic signed [CW-1:0] HALF    = CW'(longint'(180) << AF);
    localparam logic signed [CW-1:0] QUARTER = CW'(longint'(90) << AF);

    logic signed [IW-1:0] n_int;
    logic [VW-1:0]        r_v [0:NRS];
    logic [FB-1:0]        r_f [0:NRS];

    assign n_int = i_angle[DW-1:FB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0] <= VW'(n_int) + VW'(OFFS);
            r_f[0] <= i_angle[FB-1:0];
        end
    end

    // remove 360 * 2^k from the top k down
    for (genvar g = 0; g < NRS; g++) begin : g_red
        logic [VW-1:0] n_v;

        always_comb begin
            int k;
            n_v = r_v[g];
            for (int j = 0; j < SPS; j++) begin
                k = NRED - 1 - g * SPS - j;
                if (k >= 0) begin
                    if (n_v >= (VW'(360) << k)) begin
                        n_v = n_v - (VW'(360) << k);
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[g+1] <= n_v;
                r_f[g+1] <= r_f[g];
            end
        end
    end

    // fold into [-90, 90], note when the result is to be negated
    logic signed [CW-1:0] n_th;
    logic                 n_neg;
    logic signed [CW-1:0] r_x [0:NCS];
    logic signed [CW-1:0] r_y [0:NCS];
    logic signed [CW-1:0] r_z [0:NCS];
    logic                 r_neg [0:NCS];

    always_comb begin
        n_th  = (CW'(r_v[NRS][8:0]) << AF) | (CW'(r_f[NRS]) << (AF - FB));
        n_neg = 1'b0;
        if (n_th >= HALF) begin
            n_th = n_th - (HALF <<< 1);
        end
        if (n_th > QUARTER) begin
            n_th  = n_th - HALF;
            n_neg = 1'b1;
        end else if (n_th < -QUARTER) begin
            n_th  = n_th + HALF;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= CW'(rva_pkg::CORDIC_GAIN);
            r_y[0]   <= '0;
            r_z[0]   <= n_th;
            r_neg[0] <= n_neg;
        end
    end

    for (genvar g = 0; g < NCS; g++) begin : g_cordic
        logic signed [CW-1:0] n_x, n_y, n_z;

        always_comb begin
            int                   i;
            logic signed [CW-1:0] dx, dy;
            n_x = r_x[g];
            n_y = r_y[g];
            n_z = r_z[g];
            for (int j = 0; j < SPS; j++) begin
                i = g * SPS + j;
                if (i < rva_pkg::CORDIC_STEPS) begin
                    dx = n_y >>> i;
                    dy = n_x >>> i;
                    if (n_z >= 0) begin
                        n_x = n_x - dx;
                        n_y = n_y + dy;
                        n_z = n_z - rva_pkg::f_atan(i);
                    end else begin
                        n_x = n_x + dx;
                        n_y = n_y - dy;
                        n_z = n_z + rva_pkg::f_atan(i);
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g+1]   <= n_x;
                r_y[g+1]   <= n_y;
                r_z[g+1]   <= n_z;
                r_neg[g+1] <= r_neg[g];
            end
        end
    end

    logic signed [CW-1:0] r_cos, r_sin;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_neg[NCS] ? -r_x[NCS] : r_x[NCS];
            r_sin <= r_neg[NCS] ? -r_y[NCS] : r_y[NCS];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// File: rtl/rva_mat.sv
// ----------------------------------------------------------------------------
// rva_mat
// Rodrigues matrix c*I + (1-c)*u*u^T + s*[u]x in Q30, three stages.
// ----------------------------------------------------------------------------
module rva_mat (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [rva_pkg::UW-1:0] i_unit [3],
    input  logic signed [rva_pkg::CW-1:0] i_cos,
    input  logic signed [rva_pkg::CW-1:0] i_sin,
    output logic signed [rva_pkg::MW-1:0] o_m [9]
);

    localparam int UW = rva_pkg::UW;
    localparam int CW = rva_pkg::CW;
    localparam int MW = rva_pkg::MW;
    localparam int UF = rva_pkg::UNIT_FRAC;

    // pair order: xx, yy, zz, xy, xz, yz
    localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
    localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

    logic signed [2*UW-1:0]  n_uu [6];
    logic signed [UW+CW-1:0] n_w  [3];
    logic signed [UW-1:0]    r_uu [6];
    logic signed [CW-1:0]    r_w1 [3];
    logic signed [CW-1:0]    r_t, r_c1;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_uu[k] = i_unit[PA[k]] * i_unit[PB[k]];
        end
        for (int i = 0; i < 3; i++) begin
            n_w[i] = i_unit[i] * i_sin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                r_uu[k] <= UW'(n_uu[k] >>> UF);
            end
            for (int i = 0; i < 3; i++) begin
                r_w1[i] <= CW'(n_w[i] >>> UF);
            end
            r_t  <= (CW'(1) <<< UF) - i_cos;
            r_c1 <= i_cos;
        end
    end

    // (1 - c) times each pair product
    logic signed [UW+CW-1:0] n_ut [6];
    logic signed [MW-1:0]    r_ut [6];
    logic signed [CW-1:0]    r_w2 [3];
    logic signed [CW-1:0]    r_c2;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_ut[k] = r_uu[k] * r_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                r_ut[k] <= MW'(n_ut[k] >>> UF);
            end
            r_w2 <= r_w1;
            r_c2 <= r_c1;
        end
    end

    logic signed [MW-1:0] r_m [9];
    logic signed [MW-1:0] n_c, n_w0, n_w1, n_w2;

    assign n_c  = MW'(r_c2);
    assign n_w0 = MW'(r_w2[0]);
    assign n_w1 = MW'(r_w2[1]);
    assign n_w2 = MW'(r_w2[2]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= r_ut[0] + n_c;
            r_m[1] <= r_ut[3] - n_w2;
            r_m[2] <= r_ut[4] + n_w1;
            r_m[3] <= r_ut[3] + n_w2;
            r_m[4] <= r_ut[1] + n_c;
            r_m[5] <= r_ut[5] - n_w0;
            r_m[6] <= r_ut[4] - n_w1;
            r_m[7] <= r_ut[5] + n_w0;
            r_m[8] <= r_ut[2] + n_c;
        end
    end

    assign o_m = r_m;

endmodule

// File: rtl/rva_out.sv
// ----------------------------------------------------------------------------
// rva_out
// Matrix times vector, round half up and saturate to the data width, or zero for a zero axis.
// ----------------------------------------------------------------------------
module rva_out #(
    parameter int DATA_WIDTH = rva_pkg::DEF_DATA_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [rva_pkg::MW-1:0] i_m [9],
    input  logic signed [DATA_WIDTH-1:0]  i_vec [3],
    input  logic                          i_zero,
    output logic signed [DATA_WIDTH-1:0]  o_rot [3],
    output logic                          o_zero
);

    localparam int DW  = DATA_WIDTH;
    localparam int MF  = rva_pkg::f_mat_frac(DW);
    localparam int SH  = rva_pkg::UNIT_FRAC - MF;
    localparam int MPW = rva_pkg::MW - SH;
    localparam int PW  = MPW + DW;
    localparam int AW  = PW + 2;
    localparam logic signed [AW-1:0] HI = AW'((longint'(1) << (DW - 1)) - 1);
    localparam logic signed [AW-1:0] LO = -HI - AW'(1);

    logic signed [MPW-1:0] n_mp [9];
    logic signed [PW-1:0]  r_pr [9];
    logic                  r_z1;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_mp[k] = MPW'(i_m[k] >>> SH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_pr[k] <= n_mp[k] * i_vec[k % 3];
            end
            r_z1 <= i_zero;
        end
    end

    logic signed [AW-1:0] n_acc [3];
    logic signed [AW-1:0] n_res [3];
    logic signed [DW-1:0] n_sat [3];
    logic signed [DW-1:0] r_rot [3];
    logic                 r_z2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_acc[i] = (AW'(1) <<< (MF - 1)) + AW'(r_pr[3*i]) + AW'(r_pr[3*i+1])
                     + AW'(r_pr[3*i+2]);
            n_res[i] = n_acc[i] >>> MF;
            if (r_z1) begin
                n_sat[i] = '0;
            end else if (n_res[i] > HI) begin
                n_sat[i] = DW'(HI);
            end else if (n_res[i] < LO) begin
                n_sat[i] = DW'(LO);
            end else begin
                n_sat[i] = DW'(n_res[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_sat;
            r_z2  <= r_z1;
        end
    end

    assign o_rot  = r_rot;
    assign o_zero = r_z2;

endmodule

// File: rtl/rotate_vector_about_axis.sv
// ----------------------------------------------------------------------------
// rotate_vector_about_axis
// Rotates a 3D vector about an arbitrary axis by an angle in degrees.
//
//   channel   dir   tdata fields (low bit up)                      tuser
//   s_axis    in    vec_x vec_y vec_z axis_x axis_y axis_z angle   -
//   m_axis    out   rot_x rot_y rot_z                             axis_zero
//
// One beat enters per cycle while the skid register is empty. The square
// root and divide chains resolve two result bits per stage. Reset clears
// only the valid bits, the skid valid flag among them. A stalled output
// beat moves to the skid register and the pipeline holds until it is taken.
// ----------------------------------------------------------------------------
module rotate_vector_about_axis #(
    parameter int DATA_WIDTH = rva_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = rva_pkg::DEF_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg
    input  logic [((7*DATA_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // rot_x, rot_y, rot_z
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0]     o_m_axis_tdata,
    // axis_zero
    output logic                                  o_m_axis_tuser
);

    localparam int DW     = DATA_WIDTH;
    localparam int OTW    = ((3*DW+7)/8)*8;
    localparam int AX_LAT = rva_pkg::AXIS_LAT;
    localparam int CS_DLY = AX_LAT - rva_pkg::f_ang_lat(DW, FRAC_BITS);
    localparam int V_DLY  = AX_LAT + rva_pkg::MAT_LAT;
    localparam int LTOT   = V_DLY + rva_pkg::OUT_LAT;
    localparam int CW     = rva_pkg::CW;

    logic                 en;
    logic signed [DW-1:0] n_vec  [3];
    logic signed [DW-1:0] n_axis [3];
    logic                 n_zero;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_vec[i]  = i_s_axis_tdata[i*DW +: DW];
            n_axis[i] = i_s_axis_tdata[(3+i)*DW +: DW];
        end
        n_zero = (n_axis[0] == '0) && (n_axis[1] == '0) && (n_axis[2] == '0);
    end

    // valid bits travel alongside the datapath
    logic [LTOT-1:0] r_vld;
    logic            r_sk_v;

    assign en = !r_sk_v;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LTOT-2:0], i_s_axis_tvalid};
        end
    end

    logic signed [rva_pkg::UW-1:0] unit [3];
    logic signed [CW-1:0]          ang_cos, ang_sin;

    rva_axis #(.DATA_WIDTH(DW)) u_axis (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_axis (n_axis),
        .o_unit (unit)
    );

    rva_ang #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_ang (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_s_axis_tdata[6*DW +: DW]),
        .o_cos   (ang_cos),
        .o_sin   (ang_sin)
    );

    // align cosine and sine with the unit axis
    logic signed [CW-1:0] r_cd [0:CS_DLY-1];
    logic signed [CW-1:0] r_sd [0:CS_DLY-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cd[0] <= ang_cos;
            r_sd[0] <= ang_sin;
            for (int k = 1; k < CS_DLY; k++) begin
                r_cd[k] <= r_cd[k-1];
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // vector and zero flag wait for the matrix
    logic signed [DW-1:0] r_vd [0:V_DLY-1][3];
    logic                 r_zd [0:V_DLY-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vd[0] <= n_vec;
            r_zd[0] <= n_zero;
            for (int k = 1; k < V_DLY; k++) begin
                r_vd[k] <= r_vd[k-1];
                r_zd[k] <= r_zd[k-1];
            end
        end
    end

    logic signed [rva_pkg::MW-1:0] mat [9];
    logic signed [DW-1:0]          rot [3];
    logic                          rot_zero;

    rva_mat u_mat (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_unit (unit),
        .i_cos  (r_cd[CS_DLY-1]),
        .i_sin  (r_sd[CS_DLY-1]),
        .o_m    (mat)
    );

    rva_out #(.DATA_WIDTH(DW)) u_out (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_m    (mat),
        .i_vec  (r_vd[V_DLY-1]),
        .i_zero (r_zd[V_DLY-1]),
        .o_rot  (rot),
        .o_zero (rot_zero)
    );

    // skid: park a stalled beat so the pipeline can hold cleanly
    logic [3*DW-1:0] n_pipe_data;
    logic [3*DW-1:0] r_sk_data;
    logic            r_sk_z;

    assign n_pipe_data = {rot[2], rot[1], rot[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (en) begin
            r_sk_v <= r_vld[LTOT-1] && !i_m_axis_tready;
        end else if (i_m_axis_tready) begin
            r_sk_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sk_data <= n_pipe_data;
            r_sk_z    <= rot_zero;
        end
    end

    assign o_m_axis_tvalid = r_sk_v || r_vld[LTOT-1];
    assign o_m_axis_tdata  = OTW'(r_sk_v ? r_sk_data : n_pipe_data);
    assign o_m_axis_tuser  = r_sk_v ? r_sk_z : rot_zero;

    a_in_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    a_skid_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_v) |-> ($past(r_vld[LTOT-1]) && !$past(i_m_axis_tready)))
        else $error("skid filled without a stalled output beat");

    a_skid_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |=> $stable(r_vld))
        else $error("pipeline moved while the skid was full");

    a_zero_axis_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("zero axis beat carries a nonzero vector");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams vector/axis/angle beats through rotate_vector_about_axis and checks
// every output beat against a fixed-point Rodrigues rotation predictor, with
// random idling on both sides, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb;

    localparam int DW      = rva_pkg::DEF_DATA_WIDTH;
    localparam int FB      = rva_pkg::DEF_FRAC_BITS;
    localparam int MATQ    = rva_pkg::f_mat_frac(DW);
    localparam int LAT     = rva_pkg::AXIS_LAT + rva_pkg::MAT_LAT + rva_pkg::OUT_LAT;
    localparam int N_RAND  = 1300;
    localparam int WD_MAX  = 3000;
    localparam logic signed [DW-1:0] ONE = DW'(longint'(1) << FB);

    localparam longint ATAN_Q24 [24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct {
        logic signed [DW-1:0] vx, vy, vz, ax, ay, az, ang;
    } t_stim;

    typedef struct {
        logic signed [DW-1:0] rx, ry, rz;
        logic                 zero;
    } t_rot;

    typedef struct {
        t_stim s;
        bit    typed;
        t_rot  r;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [7*DW-1:0]      i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [3*DW-1:0]      o_m_axis_tdata;
    logic                 o_m_axis_tuser;

    // beats seen at the falling edge, i.e. what the next rising edge accepts
    logic                 in_beat;
    logic                 out_beat;
    logic [3*DW-1:0]      out_data;
    logic                 out_user;

    t_rot rot_q[$];
    bit   failed;
    bit   calm;
    bit   hold_req;
    int   idle_cycles;

    rotate_vector_about_axis uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned rt, b;
        rt = 0;
        b  = longint'(1) << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= rt + b) begin
                n  = n - (rt + b);
                rt = (rt >> 1) + b;
            end else begin
                rt = rt >> 1;
            end
            b = b >> 2;
        end
        return rt;
    endfunction

    function automatic longint q30_mul(input longint x, input longint y);
        return (x * y) >>> 30;
    endfunction

    function automatic t_rot rotate_vector(input t_stim s);
        longint v[3], a[3], u[3], w[3], m[3][3];
        longint unsigned mag[3], big, sum, len, q;
        longint period, r, theta, half, quarter, x, y, z, c, sn, t, dx, dy, acc, res;
        longint hi, lo;
        int p;
        bit flip;
        t_rot o;
        v = '{longint'(s.vx), longint'(s.vy), longint'(s.vz)};
        a = '{longint'(s.ax), longint'(s.ay), longint'(s.az)};
        big = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (a[i] < 0) ? longint'(-a[i]) : longint'(a[i]);
            if (mag[i] > big) big = mag[i];
        end
        if (big == 0) begin
            o.rx = '0; o.ry = '0; o.rz = '0; o.zero = 1'b1;
            return o;
        end
        p = 0;
        while ((big >> p) > 1) p++;
        for (int i = 0; i < 3; i++) begin
            if (p > 29) mag[i] = mag[i] >> (p - 29);
            else        mag[i] = mag[i] << (29 - p);
            sum += mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q    = ((mag[i] << 30) + len / 2) / len;
            u[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
        end

        // fold the angle into [-90, 90] degrees, Q24
        period  = longint'(360) << FB;
        r       = longint'(s.ang) % period;
        if (r < 0) r += period;
        theta   = r << (rva_pkg::ANG_FRAC - FB);
        half    = longint'(180) << rva_pkg::ANG_FRAC;
        quarter = longint'(90) << rva_pkg::ANG_FRAC;
        flip    = 1'b0;
        if (theta >= half) theta -= 2 * half;
        if (theta > quarter) begin
            theta -= half;
            flip = 1'b1;
        end else if (theta < -quarter) begin
            theta += half;
            flip = 1'b1;
        end

        x = rva_pkg::CORDIC_GAIN;
        y = 0;
        z = theta;
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_Q24[i];
            end else begin
                x += dx; y -= dy; z += ATAN_Q24[i];
            end
        end
        c  = flip ? -x : x;
        sn = flip ? -y : y;

        t = (longint'(1) << 30) - c;
        for (int i = 0; i < 3; i++) w[i] = q30_mul(u[i], sn);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = q30_mul(q30_mul(u[i], u[j]), t);
        m[0][0] += c;    m[1][1] += c;    m[2][2] += c;
        m[0][1] -= w[2]; m[0][2] += w[1];
        m[1][0] += w[2]; m[1][2] -= w[0];
        m[2][0] -= w[1]; m[2][1] += w[0];

        hi = (longint'(1) << (DW - 1)) - 1;
        lo = -hi - 1;
        for (int i = 0; i < 3; i++) begin
            acc = longint'(1) << (MATQ - 1);
            for (int j = 0; j < 3; j++) acc += (m[i][j] >>> (30 - MATQ)) * v[j];
            res = acc >>> MATQ;
            if (res > hi) res = hi;
            if (res < lo) res = lo;
            case (i)
                0: o.rx = res[DW-1:0];
                1: o.ry = res[DW-1:0];
                default: o.rz = res[DW-1:0];
            endcase
        end
        o.zero = 1'b0;
        return o;
    endfunction

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? {1'b0, {(DW-1){1'b1}}} : {1'b1, {(DW-1){1'b0}}};
            1, 2: return DW'($signed($urandom_range(0, 40 * ONE)) - 20 * ONE);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_stim pick_item();
        t_stim s;
        s.vx  = pick_value();
        s.vy  = pick_value();
        s.vz  = pick_value();
        s.ax  = ($urandom_range(0, 4) == 0) ? '0 : pick_value();
        s.ay  = ($urandom_range(0, 4) == 0) ? '0 : pick_value();
        s.az  = ($urandom_range(0, 4) == 0) ? '0 : pick_value();
        if ($urandom_range(0, 19) == 0) begin
            s.ax = '0; s.ay = '0; s.az = '0;
        end
        case ($urandom_range(0, 3))
            0: s.ang = DW'(longint'($urandom_range(0, 8)) * 90 * ONE - 360 * ONE);
            1: s.ang = DW'($signed($urandom_range(0, 720 * ONE)) - 360 * ONE);
            default: s.ang = $urandom();
        endcase
        return s;
    endfunction

    task automatic send_item(input t_stim s);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {s.ang, s.az, s.ay, s.ax, s.vz, s.vy, s.vx};
        do @(posedge i_clk); while (!in_beat);
    endtask

    always @(negedge i_clk) begin
        in_beat  <= i_s_axis_tvalid && o_s_axis_tready;
        out_beat <= o_m_axis_tvalid && i_m_axis_tready;
        out_data <= o_m_axis_tdata;
        out_user <= o_m_axis_tuser;
    end

    // compare each output beat with the oldest expected rotation
    always @(posedge i_clk) begin
        t_rot e;
        if (i_rst_n && out_beat) begin
            if (rot_q.size() == 0) begin
                $error("output beat with nothing expected");
                failed = 1'b1;
            end else begin
                e = rot_q.pop_front();
                if (out_data[DW-1:0] !== e.rx) begin
                    $error("rot_x expected %0d got %0d", e.rx, $signed(out_data[DW-1:0]));
                    failed = 1'b1;
                end
                if (out_data[2*DW-1:DW] !== e.ry) begin
                    $error("rot_y expected %0d got %0d", e.ry, $signed(out_data[2*DW-1:DW]));
                    failed = 1'b1;
                end
                if (out_data[3*DW-1:2*DW] !== e.rz) begin
                    $error("rot_z expected %0d got %0d", e.rz,
                           $signed(out_data[3*DW-1:2*DW]));
                    failed = 1'b1;
                end
                if (out_user !== e.zero) begin
                    $error("axis_zero expected %0d got %0d", e.zero, out_user);
                    failed = 1'b1;
                end
            end
        end
    end

    // output side: random stall bursts, one long hold-off on request
    initial begin
        int burst;
        int hold;
        bit held;
        burst = 0;
        hold  = 0;
        held  = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                hold = 300;
                held = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                i_m_axis_tready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 17) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (in_beat || out_beat || !i_rst_n) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WD_MAX) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_row  rows[$];
        t_row  rw;
        t_stim s;
        t_rot  zero_rot;
        logic signed [DW-1:0] vmax, vmin;

        calm            = 1'b0;
        hold_req        = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;

        vmax = {1'b0, {(DW-1){1'b1}}};
        vmin = {1'b1, {(DW-1){1'b0}}};
        zero_rot = '{rx: '0, ry: '0, rz: '0, zero: 1'b1};

        // zero-axis rows carry their result; the rest go through the predictor
        rows = '{
            '{'{vmax, vmax, vmax, '0, '0, '0, DW'(45 * ONE)},   1'b1, zero_rot},
            '{'{vmin, vmin, vmin, '0, '0, '0, vmin},            1'b1, zero_rot},
            '{'{ONE, 0, 0, '0, '0, ONE, '0},                   1'b0, zero_rot},
            '{'{ONE, 0, 0, '0, '0, ONE, DW'(90 * ONE)},        1'b0, zero_rot},
            '{'{ONE, ONE, 0, '0, '0, ONE, DW'(180 * ONE)},     1'b0, zero_rot},
            '{'{ONE, 0, ONE, '0, ONE, '0, DW'(270 * ONE)},     1'b0, zero_rot},
            '{'{0, ONE, ONE, ONE, '0, '0, DW'(-90 * ONE)},     1'b0, zero_rot},
            '{'{ONE, 2 * ONE, 3 * ONE, ONE, ONE, ONE, DW'(360 * ONE)}, 1'b0, zero_rot},
            '{'{ONE, 2 * ONE, 3 * ONE, ONE, ONE, ONE, DW'(-360 * ONE)}, 1'b0, zero_rot},
            '{'{ONE, ONE, ONE, ONE, -ONE, ONE, vmax},           1'b0, zero_rot},
            '{'{ONE, ONE, ONE, -ONE, ONE, -ONE, vmin},          1'b0, zero_rot},
            '{'{vmax, vmax, vmax, ONE, '0, '0, DW'(45 * ONE)},  1'b0, zero_rot},
            '{'{vmin, vmin, vmin, '0, ONE, ONE, DW'(-45 * ONE)}, 1'b0, zero_rot},
            '{'{vmax, vmin, vmax, vmax, vmax, vmax, DW'(120 * ONE)}, 1'b0, zero_rot},
            '{'{vmin, vmax, vmin, vmin, vmin, vmin, DW'(-150 * ONE)}, 1'b0, zero_rot},
            '{'{ONE, ONE, ONE, DW'(1), '0, '0, DW'(30 * ONE)},  1'b0, zero_rot},
            '{'{ONE, ONE, ONE, '0, DW'(-1), DW'(1), DW'(1)},    1'b0, zero_rot},
            '{'{ONE, -ONE, ONE, vmin, '0, '0, DW'(-1)},         1'b0, zero_rot},
            '{'{DW'(-1), DW'(1), '0, ONE, 2 * ONE, '0, DW'(179 * ONE)}, 1'b0, zero_rot}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            rw = rows[k];
            send_item(rw.s);
            rot_q.push_back(rw.typed ? rw.r : rotate_vector(rw.s));
        end

        for (int n = 0; n < N_RAND; n++) begin
            if (n == 200) hold_req = 1'b1;
            if (n == 600) begin
                i_s_axis_tvalid <= 1'b0;
                while (rot_q.size() != 0) @(posedge i_clk);
            end
            if (n == N_RAND - 200) calm = 1'b1;
            s = pick_item();
            send_item(s);
            rot_q.push_back(rotate_vector(s));
        end
        i_s_axis_tvalid <= 1'b0;

        while (rot_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        if (!failed) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
